// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every check is clocked on the rising edge and held off while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/arpc_pkg.sv =====
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int DEFAULT_CACHE_ENTRIES = 8;

    // Smallest ARP packet that carries a full IPv4 binding.
    localparam logic [15:0] MIN_PKT_LEN = 16'd28;

    // Operation codes of an input item.
    localparam logic [1:0] OP_RX     = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_SEND   = 2'd2;

    // Opcode of a received packet.
    localparam logic [15:0] PKT_OP_REQUEST = 16'd1;

    // Opcodes of an outgoing frame.
    localparam logic [1:0] FRAME_OP_REQUEST = 2'd1;
    localparam logic [1:0] FRAME_OP_REPLY   = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_REQUEST = 2'd2;
    localparam logic [1:0] KIND_LOOKUP  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd1;

    localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // capture the input beat
        logic exec;  // update the cache and load the output register
    } arpc_cmd_t;

endpackage

// ===== hw/rtl/arpc_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output arpc_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg == S_EXEC);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load = in_valid && (state_reg == S_IDLE);
        // The held item executes once the output register is free or drains now.
        cmd.exec = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_load_goes_exec, clk, rst_n, cmd.load, state_reg == S_EXEC, "load did not enter execute")
    `ASSERT_NEXT(a_exec_gives_beat, clk, rst_n, cmd.exec, out_valid_reg, "execute produced no output beat")

endmodule

// ===== hw/rtl/arpc_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arpc_dp
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEFAULT_CACHE_ENTRIES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  arpc_cmd_t            cmd,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]          cfg_data,
    input  logic [1:0]           operation,
    input  logic [15:0]          pkt_length,
    input  logic [15:0]          pkt_opcode,
    input  logic [31:0]          sender_ip,
    input  logic [47:0]          sender_mac,
    input  logic [31:0]          target_ip,
    input  logic [31:0]          query_ip,
    output logic [1:0]           result_kind,
    output logic [1:0]           frame_opcode,
    output logic [47:0]          frame_dest_mac,
    output logic [47:0]          frame_target_mac,
    output logic [31:0]          frame_target_ip,
    output logic                 found,
    output logic [47:0]          found_mac
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    // Configuration.
    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;

    // Held input item.
    logic [1:0]  op_reg;
    logic [15:0] len_reg;
    logic [15:0] opc_reg;
    logic [31:0] sip_reg;
    logic [47:0] smac_reg;
    logic [31:0] tip_reg;
    logic [31:0] qip_reg;

    // Cache.
    logic [31:0]              entry_ip_reg  [CACHE_ENTRIES];
    logic [47:0]              entry_mac_reg [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] entry_valid_reg;
    logic [IDX_W-1:0]         victim_reg, victim_next;

    // Output register.
    logic [1:0]  kind_reg, kind_next;
    logic [1:0]  fop_reg, fop_next;
    logic [47:0] dmac_reg, dmac_next;
    logic [47:0] tmac_reg, tmac_next;
    logic [31:0] tip_out_reg, tip_out_next;
    logic        found_reg, found_next;
    logic [47:0] fmac_reg, fmac_next;

    logic [31:0]              key;
    logic [CACHE_ENTRIES-1:0] match;
    logic [CACHE_ENTRIES-1:0] wr_vec;
    logic                     hit_any, free_any, do_write;
    logic [IDX_W-1:0]         hit_idx, free_idx, slot;

    assign key = (op_reg == OP_RX) ? sip_reg : qip_reg;

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            match[i] = entry_valid_reg[i] && (entry_ip_reg[i] == key);
        end
        // Lowest matching entry wins.
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
        // Highest free entry wins.
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            if (!entry_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (hit_any)
        begin
            slot = hit_idx;
        end
        else if (free_any)
        begin
            slot = free_idx;
        end
        else
        begin
            slot = victim_reg;
        end

        do_write = cmd.exec && (op_reg == OP_RX) && (len_reg >= MIN_PKT_LEN);
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            wr_vec[i] = do_write && (slot == IDX_W'(i));
        end

        victim_next = victim_reg;
        if (do_write && !hit_any && !free_any)
        begin
            victim_next = (victim_reg == LAST_IDX) ? '0 : victim_reg + 1'b1;
        end

        kind_next    = KIND_NONE;
        fop_next     = '0;
        dmac_next    = '0;
        tmac_next    = '0;
        tip_out_next = '0;
        found_next   = 1'b0;
        fmac_next    = '0;
        case (op_reg)
            OP_RX:
            begin
                if ((len_reg >= MIN_PKT_LEN) && (opc_reg == PKT_OP_REQUEST)
                    && (tip_reg == own_ip_reg))
                begin
                    kind_next    = KIND_REPLY;
                    fop_next     = FRAME_OP_REPLY;
                    dmac_next    = smac_reg;
                    tmac_next    = smac_reg;
                    tip_out_next = sip_reg;
                end
            end
            OP_LOOKUP:
            begin
                kind_next = KIND_LOOKUP;
                if (hit_any)
                begin
                    found_next = 1'b1;
                    fmac_next  = entry_mac_reg[hit_idx];
                end
            end
            OP_SEND:
            begin
                kind_next    = KIND_REQUEST;
                fop_next     = FRAME_OP_REQUEST;
                dmac_next    = BROADCAST_MAC;
                tmac_next    = BROADCAST_MAC;
                tip_out_next = qip_reg;
            end
            default:
            begin
                kind_next = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg      <= '0;
            own_mac_reg     <= '0;
            entry_valid_reg <= '0;
            victim_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                    REG_OWN_MAC: own_mac_reg <= cfg_data;
                    default:     own_ip_reg  <= own_ip_reg;
                endcase
            end
            entry_valid_reg <= entry_valid_reg | wr_vec;
            victim_reg      <= victim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            len_reg  <= pkt_length;
            opc_reg  <= pkt_opcode;
            sip_reg  <= sender_ip;
            smac_reg <= sender_mac;
            tip_reg  <= target_ip;
            qip_reg  <= query_ip;
        end
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            if (wr_vec[i])
            begin
                entry_ip_reg[i]  <= sip_reg;
                entry_mac_reg[i] <= smac_reg;
            end
        end
        if (cmd.exec)
        begin
            kind_reg    <= kind_next;
            fop_reg     <= fop_next;
            dmac_reg    <= dmac_next;
            tmac_reg    <= tmac_next;
            tip_out_reg <= tip_out_next;
            found_reg   <= found_next;
            fmac_reg    <= fmac_next;
        end
    end

    assign result_kind      = kind_reg;
    assign frame_opcode     = fop_reg;
    assign frame_dest_mac   = dmac_reg;
    assign frame_target_mac = tmac_reg;
    assign frame_target_ip  = tip_out_reg;
    assign found            = found_reg;
    assign found_mac        = fmac_reg;

    // The own MAC is part of every outgoing frame downstream; keep it observable here.
    logic own_mac_unused;
    assign own_mac_unused = ^own_mac_reg;

    `ASSERT_ALWAYS(a_single_write, clk, rst_n, $onehot0(wr_vec), "more than one cache entry written")
    `ASSERT_SAME(a_hit_matches, clk, rst_n, hit_any, match[hit_idx], "hit index does not match")

endmodule

// ===== hw/rtl/arp_cache_responder.sv =====
`timescale 1ns / 1ps
// Channel   Direction   Beat contents
// -------   ---------   -------------------------------------------------------------
// in        sink        operation, pkt_length, pkt_opcode, sender/target IP and MAC,
//                       query_ip
// out       source      result_kind, frame fields, found, found_mac
// cfg       sink        cfg_index selects own_ip (0) or own_mac (1), cfg_data
//
// Every input beat gives exactly one output beat. An item is first captured;
// then, in the execute cycle, all cache entries are compared in parallel,
// the slot is chosen, the cache is written and the output register is
// loaded. The output register lets the next beat be captured while a
// result is still stalled; the execute cycle then waits for it.
// Reset clears the valid bits, the victim pointer and the configuration;
// no clearing pass is needed.

module arp_cache_responder
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEFAULT_CACHE_ENTRIES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           operation,
    input  logic [15:0]          pkt_length,
    input  logic [15:0]          pkt_opcode,
    input  logic [31:0]          sender_ip,
    input  logic [47:0]          sender_mac,
    input  logic [31:0]          target_ip,
    input  logic [31:0]          query_ip,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           result_kind,
    output logic [1:0]           frame_opcode,
    output logic [47:0]          frame_dest_mac,
    output logic [47:0]          frame_target_mac,
    output logic [31:0]          frame_target_ip,
    output logic                 found,
    output logic [47:0]          found_mac
);

    // Controller and datapath exchange only the command struct.
    arpc_cmd_t cmd;

    arpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    arpc_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .operation        (operation),
        .pkt_length       (pkt_length),
        .pkt_opcode       (pkt_opcode),
        .sender_ip        (sender_ip),
        .sender_mac       (sender_mac),
        .target_ip        (target_ip),
        .query_ip         (query_ip),
        .result_kind      (result_kind),
        .frame_opcode     (frame_opcode),
        .frame_dest_mac   (frame_dest_mac),
        .frame_target_mac (frame_target_mac),
        .frame_target_ip  (frame_target_ip),
        .found            (found),
        .found_mac        (found_mac)
    );

endmodule

// ===== dv/arpc_tb_pkg.sv =====
`timescale 1ns / 1ps

package arpc_tb_pkg;

    import arpc_pkg::*;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] pkt_length;
        logic [15:0] pkt_opcode;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
        logic [31:0] query_ip;
    } arp_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  frame_opcode;
        logic [47:0] dest_mac;
        logic [47:0] target_mac;
        logic [31:0] target_ip;
        logic        found;
        logic [47:0] found_mac;
    } arp_result_t;

    // Mirrors the cache and the interface addresses, and keeps the result
    // beats still owed by the block in order.
    class arp_cache_shadow;
        logic [31:0] own_ip;
        logic [47:0] own_mac;
        logic [31:0] slot_ip   [DEFAULT_CACHE_ENTRIES];
        logic [47:0] slot_mac  [DEFAULT_CACHE_ENTRIES];
        bit          slot_live [DEFAULT_CACHE_ENTRIES];
        int unsigned evict_next;
        arp_result_t awaited_results[$];
        int          failures;

        function new();
            own_ip     = '0;
            own_mac    = '0;
            evict_next = 0;
            failures   = 0;
            foreach (slot_live[i])
            begin
                slot_live[i] = 1'b0;
                slot_ip[i]   = '0;
                slot_mac[i]  = '0;
            end
        endfunction

        function void absorb_item(arp_item_t it);
            arp_result_t r;
            int          slot;
            int          spare;
            r = '0;
            if (it.operation == OP_RX && it.pkt_length >= MIN_PKT_LEN)
            begin
                // A live entry with the same IP wins, then the highest free
                // entry, and only then the round-robin victim.
                slot  = -1;
                spare = -1;
                for (int i = 0; i < DEFAULT_CACHE_ENTRIES; i++)
                begin
                    if (slot < 0 && slot_live[i] && slot_ip[i] == it.sender_ip)
                        slot = i;
                    if (!slot_live[i])
                        spare = i;
                end
                if (slot < 0 && spare >= 0)
                    slot = spare;
                else if (slot < 0)
                begin
                    slot       = evict_next;
                    evict_next = (evict_next + 1) % DEFAULT_CACHE_ENTRIES;
                end
                slot_ip[slot]   = it.sender_ip;
                slot_mac[slot]  = it.sender_mac;
                slot_live[slot] = 1'b1;
                if (it.pkt_opcode == PKT_OP_REQUEST && it.target_ip == own_ip)
                begin
                    r.kind         = KIND_REPLY;
                    r.frame_opcode = FRAME_OP_REPLY;
                    r.dest_mac     = it.sender_mac;
                    r.target_mac   = it.sender_mac;
                    r.target_ip    = it.sender_ip;
                end
            end
            else if (it.operation == OP_LOOKUP)
            begin
                r.kind = KIND_LOOKUP;
                // Walking downward leaves the lowest matching entry in place.
                for (int i = DEFAULT_CACHE_ENTRIES - 1; i >= 0; i--)
                begin
                    if (slot_live[i] && slot_ip[i] == it.query_ip)
                    begin
                        r.found     = 1'b1;
                        r.found_mac = slot_mac[i];
                    end
                end
            end
            else if (it.operation == OP_SEND)
            begin
                r.kind         = KIND_REQUEST;
                r.frame_opcode = FRAME_OP_REQUEST;
                r.dest_mac     = BROADCAST_MAC;
                r.target_mac   = BROADCAST_MAC;
                r.target_ip    = it.query_ip;
            end
            awaited_results.push_back(r);
        endfunction

        function void compare_beat(arp_result_t got);
            arp_result_t want;
            if (awaited_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: kind=%0d op=%0d dst=%h tmac=%h tip=%h found=%0b fmac=%h",
                             got.kind, got.frame_opcode, got.dest_mac, got.target_mac,
                             got.target_ip, got.found, got.found_mac);
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.frame_opcode !== want.frame_opcode ||
                got.dest_mac !== want.dest_mac || got.target_mac !== want.target_mac ||
                got.target_ip !== want.target_ip || got.found !== want.found ||
                got.found_mac !== want.found_mac)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("result mismatch at %0t", $time);
                    $display("  expected kind=%0d op=%0d dst=%h tmac=%h tip=%h found=%0b fmac=%h",
                             want.kind, want.frame_opcode, want.dest_mac, want.target_mac,
                             want.target_ip, want.found, want.found_mac);
                    $display("  actual   kind=%0d op=%0d dst=%h tmac=%h tip=%h found=%0b fmac=%h",
                             got.kind, got.frame_opcode, got.dest_mac, got.target_mac,
                             got.target_ip, got.found, got.found_mac);
                end
            end
        endfunction
    endclass

endpackage

// ===== dv/arp_cache_responder_test.sv =====
`timescale 1ns / 1ps

module arp_cache_responder_test;

    import arpc_pkg::*;
    import arpc_tb_pkg::*;

    // Codes that the design package does not name: the reply opcode of a
    // received packet and the operation value that the block ignores.
    localparam logic [15:0] PKT_OP_REPLY   = 16'd2;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [31:0] OUR_IP         = 32'hC0A8_0001;
    localparam int          WATCHDOG_LIMIT = 1000;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [47:0]          cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [1:0]           operation  = '0;
    logic [15:0]          pkt_length = '0;
    logic [15:0]          pkt_opcode = '0;
    logic [31:0]          sender_ip  = '0;
    logic [47:0]          sender_mac = '0;
    logic [31:0]          target_ip  = '0;
    logic [31:0]          query_ip   = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [1:0]           result_kind;
    logic [1:0]           frame_opcode;
    logic [47:0]          frame_dest_mac;
    logic [47:0]          frame_target_mac;
    logic [31:0]          frame_target_ip;
    logic                 found;
    logic [47:0]          found_mac;

    arp_cache_shadow book;

    // Cycles in a row in which neither channel moved a beat.
    int quiet_cycles = 0;

    // Once set, neither side idles any more, so the tail of the run goes
    // through the block back to back.
    bit calm = 1'b0;

    int stall_left = 0;
    int flow_left  = 0;

    arp_cache_responder u_top (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Both channels are sampled at the rising edge, where every input has
    // been steady since the falling edge before it. A result beat is
    // checked before a new input beat is noted, though the two never
    // belong to the same item anyway.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.compare_beat('{result_kind, frame_opcode, frame_dest_mac,
                                frame_target_mac, frame_target_ip, found, found_mac});
        if (rst_n && in_valid && !in_stall)
            book.absorb_item('{operation, pkt_length, pkt_opcode, sender_ip,
                               sender_mac, target_ip, query_ip});
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // The result side holds off in bursts. Between the bursts lie
    // free-flowing stretches, now and then long ones, so that stalls land on
    // every phase of an item, its capture and its execute cycle.
    always @(negedge clk)
    begin
        if (calm)
            out_stall = 1'b0;
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall = 1'b0;
            if (flow_left > 0)
                flow_left--;
            else
            begin
                stall_left = $urandom_range(1, 18);
                flow_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(0, 12);
            end
        end
    end

    // A run that makes no progress for too long is a hang.
    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Presents one beat at a falling edge and holds it, unchanged, until
    // the block takes it. Valid is left high; the next beat or a pause
    // decides what happens at the following falling edge.
    task automatic issue(arp_item_t it);
        @(negedge clk);
        operation  = it.operation;
        pkt_length = it.pkt_length;
        pkt_opcode = it.pkt_opcode;
        sender_ip  = it.sender_ip;
        sender_mac = it.sender_mac;
        target_ip  = it.target_ip;
        query_ip   = it.query_ip;
        in_valid   = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic pause_input(int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    // Stops sending and waits until every owed result has come out. Every
    // item yields a result, so an empty queue means the block is idle; the
    // closing wait covers the output register settling.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (book.awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Configuration is only written while the block is idle, so the shadow
    // copy can take the new value at once.
    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        if (idx == REG_OWN_IP)
            book.own_ip = value[31:0];
        else
            book.own_mac = value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Random traffic around a small set of peer addresses, so that the
    // cache sees hits, refreshes and evictions, and requests often target
    // our own address. Short packets and the unused operation are mixed in
    // as noise and do not count toward the phase length. Halfway through,
    // the sender stops until the block has caught up.
    task automatic run_random_phase(int unsigned count, int unsigned calm_tail);
        logic [31:0] peers [12];
        int unsigned taken;
        int unsigned pick;
        bit          counts;
        arp_item_t   it;
        peers[0] = 32'h0000_0000;
        peers[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 12; k++)
            peers[k] = $urandom;
        taken = 0;
        while (taken < count)
        begin
            if (taken + calm_tail >= count)
                calm = 1'b1;
            it.operation  = OP_RX;
            it.pkt_length = 16'($urandom_range(28, 65535));
            it.pkt_opcode = 16'($urandom);
            it.sender_ip  = $urandom;
            it.sender_mac = 48'({$urandom, $urandom});
            it.target_ip  = $urandom;
            it.query_ip   = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 48)
            begin
                if ($urandom_range(0, 99) < 85)
                    it.sender_ip = peers[$urandom_range(0, 11)];
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    it.pkt_opcode = PKT_OP_REQUEST;
                else if (pick < 85)
                    it.pkt_opcode = PKT_OP_REPLY;
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    it.target_ip = book.own_ip;
                else if (pick < 70)
                    it.target_ip = peers[$urandom_range(0, 11)];
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    it.pkt_length = 16'($urandom_range(0, 27));
                else if (pick < 13)
                    it.pkt_length = MIN_PKT_LEN;
            end
            else if (pick < 78)
            begin
                it.operation = OP_LOOKUP;
                if ($urandom_range(0, 99) < 70)
                    it.query_ip = peers[$urandom_range(0, 11)];
            end
            else if (pick < 95)
                it.operation = OP_SEND;
            else
                it.operation = OP_UNUSED;
            counts = !(it.operation == OP_UNUSED ||
                       (it.operation == OP_RX && it.pkt_length < MIN_PKT_LEN));
            if (!calm && $urandom_range(0, 7) == 0)
                pause_input($urandom_range(1, 18));
            issue(it);
            if (counts)
            begin
                taken++;
                if (taken == count / 2)
                    wait_drained();
            end
        end
    endtask

    initial
    begin : stimulus
        book = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_register(REG_OWN_IP, {16'd0, OUR_IP});
        set_register(REG_OWN_MAC, 48'h0200_5E10_2030);

        // Directed part. A lookup on the empty cache must miss, and short
        // packets must leave the cache alone even when aimed at us.
        issue('{OP_LOOKUP, 16'd0, 16'd0, 32'd0, 48'd0, 32'd0, 32'd0});
        issue('{OP_RX, 16'd27, PKT_OP_REQUEST, 32'h0A00_0009, 48'h0A0A_0000_0009,
                OUR_IP, 32'd0});
        issue('{OP_RX, 16'd0, PKT_OP_REQUEST, 32'h0A00_0009, 48'h0A0A_0000_0009,
                OUR_IP, 32'd0});
        // Requests for us at the shortest and longest lengths, with the
        // extreme sender addresses; both must be answered.
        issue('{OP_RX, 16'd28, PKT_OP_REQUEST, 32'h0000_0000, 48'hFFFF_FFFF_FFFF,
                OUR_IP, 32'd0});
        issue('{OP_RX, 16'hFFFF, PKT_OP_REQUEST, 32'hFFFF_FFFF, 48'h0000_0000_0000,
                OUR_IP, 32'hFFFF_FFFF});
        // A reply, a request for another host and a bogus opcode only
        // update the cache.
        issue('{OP_RX, 16'd60, PKT_OP_REPLY, 32'h0A00_0001, 48'h0A0A_0000_0001,
                OUR_IP, 32'd0});
        issue('{OP_RX, 16'd60, PKT_OP_REQUEST, 32'h0A00_0002, 48'h0A0A_0000_0002,
                32'h0A00_00FE, 32'd0});
        issue('{OP_RX, 16'd42, 16'hFFFF, 32'h0A00_0003, 48'h0A0A_0000_0003,
                OUR_IP, 32'd0});
        issue('{OP_LOOKUP, 16'd0, 16'd0, 32'd0, 48'd0, 32'd0, 32'h0000_0000});
        issue('{OP_LOOKUP, 16'd0, 16'd0, 32'd0, 48'd0, 32'd0, 32'h0A00_00FF});
        issue('{OP_SEND, 16'd0, 16'd0, 32'd0, 48'd0, 32'd0, 32'h0000_0000});
        issue('{OP_SEND, 16'd0, 16'd0, 32'd0, 48'd0, 32'd0, 32'hFFFF_FFFF});
        issue('{OP_UNUSED, 16'd28, PKT_OP_REQUEST, 32'h0A00_0009, 48'h0A0A_0000_0009,
                OUR_IP, 32'h0A00_0009});
        // Five entries are in use; three more fill the cache and the last
        // two push out victims in round-robin order.
        for (int k = 4; k <= 8; k++)
            issue('{OP_RX, 16'd46, (k % 2 == 0) ? PKT_OP_REQUEST : PKT_OP_REPLY,
                    32'h0A00_0000 + k, {16'h0A0A, 32'(k)}, OUR_IP, 32'd0});
        // A known sender refreshes its own entry rather than taking a new one.
        issue('{OP_RX, 16'd28, PKT_OP_REQUEST, 32'h0000_0000, 48'h1234_5678_9ABC,
                OUR_IP, 32'd0});
        issue('{OP_LOOKUP, 16'd0, 16'd0, 32'd0, 48'd0, 32'd0, 32'h0000_0000});
        issue('{OP_LOOKUP, 16'd0, 16'd0, 32'd0, 48'd0, 32'd0, 32'h0A00_0006});
        issue('{OP_LOOKUP, 16'd0, 16'd0, 32'd0, 48'd0, 32'd0, 32'h0A00_0007});

        // Random phases, each under its own setting of the addresses, the
        // extremes among them. The last phase ends without any idling.
        wait_drained();
        set_register(REG_OWN_IP, 48'd0);
        set_register(REG_OWN_MAC, 48'd0);
        run_random_phase(210, 0);

        wait_drained();
        set_register(REG_OWN_IP, 48'h0000_FFFF_FFFF);
        set_register(REG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        run_random_phase(210, 0);

        wait_drained();
        set_register(REG_OWN_MAC, 48'({$urandom, $urandom}));
        set_register(REG_OWN_IP, {16'd0, 32'($urandom)});
        run_random_phase(210, 0);

        wait_drained();
        set_register(REG_OWN_IP, {16'd0, 32'($urandom)});
        set_register(REG_OWN_MAC, 48'({$urandom, $urandom}));
        run_random_phase(300, 150);

        // Any stray beat after the last expected one shows up here.
        wait_drained();
        repeat (12) @(negedge clk);
        if (book.failures == 0 && book.awaited_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_ctrl.sv
hw/rtl/arpc_dp.sv
hw/rtl/arp_cache_responder.sv
dv/arpc_tb_pkg.sv
dv/arp_cache_responder_test.sv
